### src/dhmc_pkg.sv
// Shared types and constants for the desk height motion controller.
// Used by dhmc_core and desk_height_motion_controller_top; no dependencies.
`default_nettype none

package dhmc_pkg;

  // Default window geometry
  localparam int WINDOW_BITS_DEF = 32;
  localparam int SYNC_BITS_DEF   = 23;

  // Configuration register indexes
  localparam logic [2:0] CFG_HEIGHT_MIN      = 3'd0;
  localparam logic [2:0] CFG_HEIGHT_MAX      = 3'd1;
  localparam logic [2:0] CFG_AUTO_STOP_TICKS = 3'd2;
  localparam logic [2:0] CFG_SERIAL_GAP      = 3'd3;
  localparam logic [2:0] CFG_SYNC_PATTERN    = 3'd4;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 23;

  // Configuration reset values
  localparam logic [7:0]  HEIGHT_MIN_RST      = 8'd60;
  localparam logic [7:0]  HEIGHT_MAX_RST      = 8'd120;
  localparam logic [15:0] AUTO_STOP_TICKS_RST = 16'd1500;
  localparam logic [15:0] SERIAL_GAP_RST      = 16'd1000;
  localparam logic [22:0] SYNC_PATTERN_RST    = 23'd6289917;

  // Movement directions
  localparam logic [1:0] MOVE_STOP = 2'd0;
  localparam logic [1:0] MOVE_UP   = 2'd1;
  localparam logic [1:0] MOVE_DOWN = 2'd2;

  // Drive level bits
  localparam logic [3:0] LV_UP   = 4'b0001;
  localparam logic [3:0] LV_PA   = 4'b0010;
  localparam logic [3:0] LV_PB   = 4'b0100;
  localparam logic [3:0] LV_DOWN = 4'b1000;

  // Serial command opcodes
  localparam logic [7:0] CMD_SET_HEIGHT = 8'h01;
  localparam logic [7:0] CMD_STOP       = 8'h02;
  localparam logic [7:0] CMD_UP         = 8'h03;
  localparam logic [7:0] CMD_DOWN       = 8'h04;
  localparam logic [7:0] CMD_PRESET     = 8'h05;

  // Preset numbers
  localparam logic [7:0] PRESET_1 = 8'd1;
  localparam logic [7:0] PRESET_2 = 8'd2;
  localparam logic [7:0] PRESET_3 = 8'd3;
  localparam logic [7:0] PRESET_4 = 8'd4;

  localparam logic [15:0] TICK_SAT = 16'hFFFF;

  typedef struct packed {
    logic [7:0]  height_min;
    logic [7:0]  height_max;
    logic [15:0] auto_stop_ticks;
    logic [15:0] serial_gap_ticks;
    logic [22:0] sync_pattern;
  } cfg_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       rx_valid;
    logic       key_down;
    logic       key_preset_b;
    logic       key_preset_a;
    logic       key_up;
    logic       signal_bit;
  } in_item_t;

  typedef struct packed {
    logic [1:0] motion;
    logic       height_report;
    logic [7:0] height;
    logic       drive_down;
    logic       drive_preset_b;
    logic       drive_preset_a;
    logic       drive_up;
    logic       signal_echo;
  } out_item_t;

endpackage

`default_nettype wire

### src/dhmc_core.sv
// Controller state and per-tick update: serial commands, height frame decode,
// hand switch handling and movement stop control. Depends on dhmc_pkg.
`default_nettype none

module dhmc_core #(
  parameter int WINDOW_BITS = dhmc_pkg::WINDOW_BITS_DEF,
  parameter int SYNC_BITS   = dhmc_pkg::SYNC_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               step_en,
  input  wire dhmc_pkg::cfg_t     cfg,
  input  wire dhmc_pkg::in_item_t item,
  output dhmc_pkg::out_item_t     result
);

  logic [WINDOW_BITS-1:0] win_r, win_nxt;
  logic [7:0]  cur_h_r, cur_h_nxt;
  logic [7:0]  tgt_h_r, tgt_h_nxt;
  logic [1:0]  dir_r, dir_nxt;
  logic        ahm_r, ahm_nxt;
  logic        apm_r, apm_nxt;
  logic        ovr_r, ovr_nxt;
  logic [3:0]  lv_r, lv_nxt;
  logic [15:0] tsc_r, tsc_nxt;
  logic [7:0]  pend_r, pend_nxt;
  logic [15:0] tss_r, tss_nxt;
  logic        report;

  // Compute the next state for one tick
  always_comb begin
    logic [7:0] h_raw;
    logic [7:0] h;
    logic [7:0] arg;
    logic [2:0] n;
    logic       any;
    logic       up, pa, pb, dn;

    win_nxt   = win_r;
    cur_h_nxt = cur_h_r;
    tgt_h_nxt = tgt_h_r;
    dir_nxt   = dir_r;
    ahm_nxt   = ahm_r;
    apm_nxt   = apm_r;
    ovr_nxt   = ovr_r;
    lv_nxt    = lv_r;
    pend_nxt  = pend_r;
    report    = 1'b0;
    arg       = item.rx_byte;
    up        = item.key_up;
    pa        = item.key_preset_a;
    pb        = item.key_preset_b;
    dn        = item.key_down;

    // advance both timers, saturating
    tsc_nxt = (tsc_r != dhmc_pkg::TICK_SAT) ? tsc_r + 16'd1 : tsc_r;
    tss_nxt = (tss_r != dhmc_pkg::TICK_SAT) ? tss_r + 16'd1 : tss_r;

    // serial byte: collect opcode, run on argument
    if (item.rx_valid && (arg != 8'd0)) begin
      if (tss_nxt >= cfg.serial_gap_ticks) pend_nxt = 8'd0;
      tss_nxt = 16'd0;
      if (pend_nxt == 8'd0) begin
        pend_nxt = arg;
      end else begin
        case (pend_nxt)
          dhmc_pkg::CMD_SET_HEIGHT: begin
            if (!ovr_nxt) begin
              ahm_nxt = 1'b1;
              if ({1'b0, arg} > ({1'b0, cur_h_nxt} + 9'd1)) tgt_h_nxt = arg - 8'd1;
              else tgt_h_nxt = arg + 8'd1;
              if (cur_h_nxt < tgt_h_nxt) begin
                dir_nxt = dhmc_pkg::MOVE_UP;
                lv_nxt  = (lv_nxt & ~dhmc_pkg::LV_DOWN) | dhmc_pkg::LV_UP;
              end else if (cur_h_nxt > tgt_h_nxt) begin
                dir_nxt = dhmc_pkg::MOVE_DOWN;
                lv_nxt  = (lv_nxt & ~dhmc_pkg::LV_UP) | dhmc_pkg::LV_DOWN;
              end
            end
          end
          dhmc_pkg::CMD_PRESET: begin
            if (!ovr_nxt) begin
              tsc_nxt = 16'd0;
              ahm_nxt = 1'b0;
              apm_nxt = 1'b1;
              case (arg)
                dhmc_pkg::PRESET_1: lv_nxt = lv_nxt | dhmc_pkg::LV_PB;
                dhmc_pkg::PRESET_2: lv_nxt = lv_nxt | dhmc_pkg::LV_PA;
                dhmc_pkg::PRESET_3: lv_nxt = lv_nxt | dhmc_pkg::LV_PA | dhmc_pkg::LV_DOWN;
                dhmc_pkg::PRESET_4: lv_nxt = lv_nxt | dhmc_pkg::LV_PB | dhmc_pkg::LV_DOWN;
                default: ;
              endcase
            end
          end
          dhmc_pkg::CMD_STOP: begin
            if (!ovr_nxt) begin
              dir_nxt   = dhmc_pkg::MOVE_STOP;
              lv_nxt    = 4'd0;
              ahm_nxt   = 1'b0;
              apm_nxt   = 1'b0;
              tgt_h_nxt = cur_h_nxt;
            end
          end
          dhmc_pkg::CMD_UP: begin
            ahm_nxt = 1'b0;
            apm_nxt = 1'b0;
            dir_nxt = dhmc_pkg::MOVE_UP;
            lv_nxt  = (lv_nxt & ~dhmc_pkg::LV_DOWN) | dhmc_pkg::LV_UP;
          end
          dhmc_pkg::CMD_DOWN: begin
            ahm_nxt = 1'b0;
            apm_nxt = 1'b0;
            dir_nxt = dhmc_pkg::MOVE_DOWN;
            lv_nxt  = (lv_nxt & ~dhmc_pkg::LV_UP) | dhmc_pkg::LV_DOWN;
          end
          default: ;
        endcase
        pend_nxt = 8'd0;
      end
    end

    // shift the line bit in and look for a framed height
    win_nxt = {item.signal_bit, win_r[WINDOW_BITS-1:1]};
    for (int i = 0; i < 8; i++) begin
      h_raw[i] = win_nxt[(SYNC_BITS + i) % WINDOW_BITS];
    end
    h = ~h_raw;
    if ((win_nxt[SYNC_BITS-1:0] == cfg.sync_pattern[SYNC_BITS-1:0]) &&
        (h >= cfg.height_min) && (h <= cfg.height_max)) begin
      if (h != cur_h_nxt) tsc_nxt = 16'd0;
      cur_h_nxt = h;
      report    = 1'b1;
    end

    // hand switches
    n   = {2'b00, up} + {2'b00, pa} + {2'b00, pb} + {2'b00, dn};
    any = (n != 3'd0);
    if (any) tsc_nxt = 16'd0;
    if (ovr_nxt) begin
      // release of both move keys ends the override
      if (!up && !dn) begin
        dir_nxt   = dhmc_pkg::MOVE_STOP;
        lv_nxt    = 4'd0;
        ahm_nxt   = 1'b0;
        apm_nxt   = 1'b0;
        tgt_h_nxt = cur_h_nxt;
        ovr_nxt   = 1'b0;
      end
    end else begin
      if (up && (n == 3'd1)) begin
        dir_nxt = dhmc_pkg::MOVE_UP;
        lv_nxt  = (lv_nxt & ~dhmc_pkg::LV_DOWN) | dhmc_pkg::LV_UP;
        ovr_nxt = 1'b1;
        ahm_nxt = 1'b0;
        apm_nxt = 1'b0;
      end else if (dn && (n == 3'd1)) begin
        dir_nxt = dhmc_pkg::MOVE_DOWN;
        lv_nxt  = (lv_nxt & ~dhmc_pkg::LV_UP) | dhmc_pkg::LV_DOWN;
        ovr_nxt = 1'b1;
        ahm_nxt = 1'b0;
        apm_nxt = 1'b0;
      end
      // both move keys together
      if ((n == 3'd2) && up && dn) begin
        lv_nxt  = lv_nxt | dhmc_pkg::LV_UP | dhmc_pkg::LV_DOWN;
        ovr_nxt = 1'b1;
        ahm_nxt = 1'b0;
        apm_nxt = 1'b0;
      end
      // preset keys pass through
      if (((n == 3'd2) && dn && (pa || pb)) || ((n == 3'd1) && (pa || pb))) begin
        lv_nxt  = (lv_nxt & dhmc_pkg::LV_UP) | (pa ? dhmc_pkg::LV_PA : 4'd0) |
                  (pb ? dhmc_pkg::LV_PB : 4'd0) | (dn ? dhmc_pkg::LV_DOWN : 4'd0);
        tsc_nxt = 16'd0;
        apm_nxt = 1'b1;
        ahm_nxt = 1'b0;
        ovr_nxt = 1'b0;
      end
    end

    // stop at target or after preset idle timeout
    if (!ovr_nxt) begin
      if (ahm_nxt) begin
        if ((dir_nxt == dhmc_pkg::MOVE_UP) && (cur_h_nxt >= tgt_h_nxt)) begin
          dir_nxt   = dhmc_pkg::MOVE_STOP;
          lv_nxt    = 4'd0;
          ahm_nxt   = 1'b0;
          apm_nxt   = 1'b0;
          tgt_h_nxt = cur_h_nxt;
        end
        if ((dir_nxt == dhmc_pkg::MOVE_DOWN) && (cur_h_nxt <= tgt_h_nxt)) begin
          dir_nxt   = dhmc_pkg::MOVE_STOP;
          lv_nxt    = 4'd0;
          ahm_nxt   = 1'b0;
          apm_nxt   = 1'b0;
          tgt_h_nxt = cur_h_nxt;
        end
      end else if (apm_nxt && !any) begin
        if (tsc_nxt >= cfg.auto_stop_ticks) begin
          dir_nxt   = dhmc_pkg::MOVE_STOP;
          lv_nxt    = 4'd0;
          ahm_nxt   = 1'b0;
          apm_nxt   = 1'b0;
          tgt_h_nxt = cur_h_nxt;
        end
      end
    end
  end

  // Result of this tick
  always_comb begin
    result.signal_echo    = item.signal_bit;
    result.drive_up       = lv_nxt[0];
    result.drive_preset_a = lv_nxt[1];
    result.drive_preset_b = lv_nxt[2];
    result.drive_down     = lv_nxt[3];
    result.height         = cur_h_nxt;
    result.height_report  = report;
    result.motion         = dir_nxt;
  end

  // Commit state on each accepted request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r   <= '0;
      cur_h_r <= 8'd0;
      tgt_h_r <= 8'd0;
      dir_r   <= dhmc_pkg::MOVE_STOP;
      ahm_r   <= 1'b1;
      apm_r   <= 1'b0;
      ovr_r   <= 1'b0;
      lv_r    <= 4'd0;
      tsc_r   <= 16'd0;
      pend_r  <= 8'd0;
      tss_r   <= 16'd0;
    end else if (step_en) begin
      win_r   <= win_nxt;
      cur_h_r <= cur_h_nxt;
      tgt_h_r <= tgt_h_nxt;
      dir_r   <= dir_nxt;
      ahm_r   <= ahm_nxt;
      apm_r   <= apm_nxt;
      ovr_r   <= ovr_nxt;
      lv_r    <= lv_nxt;
      tsc_r   <= tsc_nxt;
      pend_r  <= pend_nxt;
      tss_r   <= tss_nxt;
    end
  end

endmodule

`default_nettype wire

### src/desk_height_motion_controller_top.sv
// Desk height motion controller, top level: stream ports, configuration
// registers and the result register. Depends on dhmc_pkg and dhmc_core.
// A result appears on out_tvalid in the cycle after its request is taken.
// Throughput: one request per cycle unless out_tready stalls a held result;
// the state update is a single registered step. Reset (rst_n low, synchronous):
// state and configuration return to defaults, the result register empties.
`default_nettype none

module desk_height_motion_controller_top #(
  parameter int WINDOW_BITS = dhmc_pkg::WINDOW_BITS_DEF,
  parameter int SYNC_BITS   = dhmc_pkg::SYNC_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // in_tdata, from bit 0: signal_bit, key_up, key_preset_a, key_preset_b,
  // key_down, rx_valid, rx_byte[7:0], two zero pad bits
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  input  wire logic [15:0]                      in_tdata,
  // out_tdata, from bit 0: signal_echo, drive_up, drive_preset_a,
  // drive_preset_b, drive_down, height[7:0], height_report, motion[1:0]
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  output logic [15:0]                           out_tdata,
  input  wire logic                             cfg_wr_en,
  input  wire logic [dhmc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [dhmc_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  dhmc_pkg::cfg_t      cfg_r;
  dhmc_pkg::in_item_t  item;
  dhmc_pkg::out_item_t result;
  logic [15:0]         out_data_r;
  logic                out_valid_r;
  logic                accept;

  // Accept while the result register is empty or draining
  assign in_tready  = !out_valid_r || out_tready;
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Unpack the request
  assign item = dhmc_pkg::in_item_t'(in_tdata[13:0]);

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.height_min       <= dhmc_pkg::HEIGHT_MIN_RST;
      cfg_r.height_max       <= dhmc_pkg::HEIGHT_MAX_RST;
      cfg_r.auto_stop_ticks  <= dhmc_pkg::AUTO_STOP_TICKS_RST;
      cfg_r.serial_gap_ticks <= dhmc_pkg::SERIAL_GAP_RST;
      cfg_r.sync_pattern     <= dhmc_pkg::SYNC_PATTERN_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        dhmc_pkg::CFG_HEIGHT_MIN:      cfg_r.height_min       <= cfg_wdata[7:0];
        dhmc_pkg::CFG_HEIGHT_MAX:      cfg_r.height_max       <= cfg_wdata[7:0];
        dhmc_pkg::CFG_AUTO_STOP_TICKS: cfg_r.auto_stop_ticks  <= cfg_wdata[15:0];
        dhmc_pkg::CFG_SERIAL_GAP:      cfg_r.serial_gap_ticks <= cfg_wdata[15:0];
        dhmc_pkg::CFG_SYNC_PATTERN:    cfg_r.sync_pattern     <= cfg_wdata[22:0];
        default: ;
      endcase
    end
  end

  dhmc_core #(
    .WINDOW_BITS (WINDOW_BITS),
    .SYNC_BITS   (SYNC_BITS)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (accept),
    .cfg     (cfg_r),
    .item    (item),
    .result  (result)
  );

  // Result register valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result register payload
  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= 16'(result);
    end
  end

endmodule

`default_nettype wire

### tb/desk_height_motion_controller_top_tb.sv
`timescale 1ns / 100ps
// Testbench for desk_height_motion_controller_top: directed and random tick streams,
// each result checked against a behavioral predictor of the controller kept here.
// Depends on dhmc_pkg and the top-level RTL only.

module desk_height_motion_controller_top_tb;
  import dhmc_pkg::*;

  localparam int WIN            = WINDOW_BITS_DEF;
  localparam int SYNC           = SYNC_BITS_DEF;
  localparam int IN_PAD         = 16 - $bits(in_item_t);
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int ITEMS_PER_PHASE = 350;

  // Hand-switch masks, same bit order as the drive levels
  localparam logic [3:0] KEY_NONE = 4'b0000;
  localparam logic [3:0] KEY_UP   = 4'b0001;
  localparam logic [3:0] KEY_PA   = 4'b0010;
  localparam logic [3:0] KEY_PB   = 4'b0100;
  localparam logic [3:0] KEY_DOWN = 4'b1000;
  localparam logic [7:0] ZERO_BYTE = 8'h00;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [15:0]            in_tdata;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [15:0]            out_tdata;
  logic                   cfg_wr_en;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_wdata;

  desk_height_motion_controller_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  // Controller state as predicted from the accepted requests
  cfg_t        desk_cfg;
  logic [WIN-1:0] line_window;
  logic [7:0]  cur_height;
  logic [7:0]  tgt_height;
  logic [1:0]  move_dir;
  logic        auto_height;
  logic        auto_preset;
  logic        key_override;
  logic [3:0]  drive_lv;
  logic [15:0] idle_ticks;
  logic [15:0] serial_quiet;
  logic [7:0]  pending_op;

  out_item_t   expected_results[$];

  // Stimulus plans: line bits and serial bytes (valid, byte) waiting to go out
  logic        line_bits[$];
  logic [8:0]  rx_plan[$];
  logic [3:0]  key_level;
  int          key_hold;
  logic        steady;

  int errors = 0;
  int ticks_sent = 0;
  int heights_accepted = 0;
  int settings_applied = 0;
  int quiet_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor

  function automatic void start_up();
    move_dir = MOVE_UP;
    drive_lv = (drive_lv & ~LV_DOWN) | LV_UP;
  endfunction

  function automatic void start_down();
    move_dir = MOVE_DOWN;
    drive_lv = (drive_lv & ~LV_UP) | LV_DOWN;
  endfunction

  function automatic void stop_desk();
    move_dir    = MOVE_STOP;
    drive_lv    = '0;
    auto_height = 1'b0;
    auto_preset = 1'b0;
    tgt_height  = cur_height;
  endfunction

  function automatic void run_serial_command(logic [7:0] op, logic [7:0] arg);
    case (op)
      CMD_SET_HEIGHT: if (!key_override) begin
        auto_height = 1'b1;
        // aim one short of the request, from whichever side
        if (int'(arg) - int'(cur_height) > 1) tgt_height = arg - 8'd1;
        else tgt_height = arg + 8'd1;
        if (cur_height < tgt_height) start_up();
        else if (cur_height > tgt_height) start_down();
      end
      CMD_PRESET: if (!key_override) begin
        idle_ticks  = '0;
        auto_height = 1'b0;
        auto_preset = 1'b1;
        case (arg)
          PRESET_1: drive_lv = drive_lv | LV_PB;
          PRESET_2: drive_lv = drive_lv | LV_PA;
          PRESET_3: drive_lv = drive_lv | LV_PA | LV_DOWN;
          PRESET_4: drive_lv = drive_lv | LV_PB | LV_DOWN;
          default: ;
        endcase
      end
      CMD_STOP: if (!key_override) stop_desk();
      CMD_UP: begin
        auto_height = 1'b0;
        auto_preset = 1'b0;
        start_up();
      end
      CMD_DOWN: begin
        auto_height = 1'b0;
        auto_preset = 1'b0;
        start_down();
      end
      default: ;
    endcase
  endfunction

  // Shift in one line bit; true when a plausible height frame completes
  function automatic logic take_line_bit(logic b);
    logic [7:0] raw;
    logic [7:0] h;
    line_window = {b, line_window[WIN-1:1]};
    if (line_window[SYNC-1:0] != desk_cfg.sync_pattern[SYNC-1:0]) return 1'b0;
    for (int i = 0; i < 8; i++) raw[i] = line_window[(SYNC + i) % WIN];
    h = ~raw;
    if (h < desk_cfg.height_min || h > desk_cfg.height_max) return 1'b0;
    if (h != cur_height) idle_ticks = '0;
    cur_height = h;
    return 1'b1;
  endfunction

  // Apply the hand-switch levels; true when any key is down
  function automatic logic apply_keys(logic up, logic pa, logic pb, logic dn);
    int   n;
    logic any;
    n   = int'(up) + int'(pa) + int'(pb) + int'(dn);
    any = (n > 0);
    if (any) idle_ticks = '0;
    if (key_override) begin
      if (!up && !dn) begin
        stop_desk();
        key_override = 1'b0;
        auto_preset  = 1'b0;
      end
      return any;
    end
    if (up && n == 1) begin
      start_up();
      key_override = 1'b1;
      auto_height  = 1'b0;
      auto_preset  = 1'b0;
    end else if (dn && n == 1) begin
      start_down();
      key_override = 1'b1;
      auto_height  = 1'b0;
      auto_preset  = 1'b0;
    end
    if (n == 2 && up && dn) begin
      drive_lv     = drive_lv | LV_UP | LV_DOWN;
      key_override = 1'b1;
      auto_height  = 1'b0;
      auto_preset  = 1'b0;
    end
    // preset keys pass straight through, optionally with the down key
    if ((n == 2 && dn && (pa || pb)) || (n == 1 && (pa || pb))) begin
      drive_lv = (drive_lv & LV_UP) | (pa ? LV_PA : 4'b0) | (pb ? LV_PB : 4'b0)
               | (dn ? LV_DOWN : 4'b0);
      idle_ticks   = '0;
      auto_preset  = 1'b1;
      auto_height  = 1'b0;
      key_override = 1'b0;
    end
    return any;
  endfunction

  function automatic out_item_t predict_tick(in_item_t it);
    out_item_t r;
    logic      report;
    logic      any;
    if (idle_ticks != TICK_SAT) idle_ticks++;
    if (serial_quiet != TICK_SAT) serial_quiet++;

    // serial: a long silence drops a half command
    if (it.rx_valid && it.rx_byte != ZERO_BYTE) begin
      if (serial_quiet >= desk_cfg.serial_gap_ticks) pending_op = ZERO_BYTE;
      serial_quiet = '0;
      if (pending_op == ZERO_BYTE) begin
        pending_op = it.rx_byte;
      end else begin
        run_serial_command(pending_op, it.rx_byte);
        pending_op = ZERO_BYTE;
      end
    end

    report = take_line_bit(it.signal_bit);
    any    = apply_keys(it.key_up, it.key_preset_a, it.key_preset_b, it.key_down);

    // movement control
    if (!key_override) begin
      if (auto_height) begin
        if (move_dir == MOVE_UP && cur_height >= tgt_height) stop_desk();
        if (move_dir == MOVE_DOWN && cur_height <= tgt_height) stop_desk();
      end else if (auto_preset && !any) begin
        if (idle_ticks >= desk_cfg.auto_stop_ticks) stop_desk();
      end
    end

    r.signal_echo    = it.signal_bit;
    r.drive_up       = (drive_lv & LV_UP) != '0;
    r.drive_preset_a = (drive_lv & LV_PA) != '0;
    r.drive_preset_b = (drive_lv & LV_PB) != '0;
    r.drive_down     = (drive_lv & LV_DOWN) != '0;
    r.height         = cur_height;
    r.height_report  = report;
    r.motion         = move_dir;
    if (report) heights_accepted++;
    return r;
  endfunction

  // ------------------------------------------------------------ stimulus plans

  function automatic void queue_height_frame(logic [7:0] h);
    for (int i = 0; i < SYNC; i++) line_bits.push_back(desk_cfg.sync_pattern[i]);
    for (int i = 0; i < 8; i++) line_bits.push_back(~h[i]);
    repeat (WIN - SYNC - 8) line_bits.push_back(1'($urandom));
  endfunction

  function automatic void plan_command(logic [7:0] op, logic [7:0] arg, int spacing);
    rx_plan.push_back({1'b1, op});
    repeat (spacing) rx_plan.push_back({1'b0, 8'($urandom)});
    rx_plan.push_back({1'b1, arg});
  endfunction

  function automatic logic [7:0] pick_opcode();
    case ($urandom_range(0, 11))
      0, 1, 2: return CMD_SET_HEIGHT;
      3, 4:    return CMD_PRESET;
      5:       return CMD_STOP;
      6, 7:    return CMD_UP;
      8, 9:    return CMD_DOWN;
      10:      return 8'($urandom_range(int'(CMD_PRESET) + 1, 255));
      default: return 8'($urandom_range(1, 255));
    endcase
  endfunction

  // Build one random tick from the running line, key and serial plans
  function automatic in_item_t next_random_tick();
    in_item_t   it;
    logic [8:0] rx;
    logic [7:0] lo;
    logic [7:0] hi;
    logic [7:0] op;
    logic [7:0] arg;
    int         silence;

    // line: mostly whole frames, sometimes a burst of noise
    if (line_bits.size() == 0) begin
      lo = (desk_cfg.height_min <= desk_cfg.height_max) ? desk_cfg.height_min
                                                        : desk_cfg.height_max;
      hi = (desk_cfg.height_min <= desk_cfg.height_max) ? desk_cfg.height_max
                                                        : desk_cfg.height_min;
      case ($urandom_range(0, 5))
        0: repeat ($urandom_range(1, 8)) line_bits.push_back(1'($urandom));
        1: queue_height_frame(8'($urandom));
        2: case ($urandom_range(0, 3))
             0:       queue_height_frame(lo - 8'd1);
             1:       queue_height_frame(lo);
             2:       queue_height_frame(hi);
             default: queue_height_frame(hi + 8'd1);
           endcase
        default: queue_height_frame(8'($urandom_range(lo, hi)));
      endcase
    end

    // keys: hold a level for a while, released half of the time
    if (key_hold == 0) begin
      key_hold = $urandom_range(1, 30);
      case ($urandom_range(0, 9))
        5:       key_level = KEY_UP;
        6:       key_level = KEY_DOWN;
        7:       case ($urandom_range(0, 3))
                   0:       key_level = KEY_PA;
                   1:       key_level = KEY_PB;
                   2:       key_level = KEY_PA | KEY_DOWN;
                   default: key_level = KEY_PB | KEY_DOWN;
                 endcase
        8:       key_level = KEY_UP | KEY_DOWN;
        9:       key_level = 4'($urandom);
        default: key_level = KEY_NONE;
      endcase
    end
    key_hold--;

    // serial: commands, quiet stretches, orphaned halves and zero bytes
    if (rx_plan.size() == 0) begin
      case ($urandom_range(0, 9))
        0, 1, 2: repeat ($urandom_range(1, 6)) rx_plan.push_back({1'b0, 8'($urandom)});
        3: begin
          rx_plan.push_back({1'b1, pick_opcode()});
          silence = int'(desk_cfg.serial_gap_ticks) - 2 + int'($urandom_range(0, 3));
          if (silence < 0) silence = 0;
          if (silence > 40) silence = $urandom_range(1, 10);
          repeat (silence) rx_plan.push_back({1'b0, 8'($urandom)});
        end
        4: rx_plan.push_back({1'b1, ZERO_BYTE});
        default: begin
          op = pick_opcode();
          case (op)
            CMD_SET_HEIGHT: arg = ($urandom_range(0, 3) == 0) ? 8'($urandom)
                                : cur_height + 8'($urandom_range(0, 40)) - 8'd20;
            CMD_PRESET:     arg = ($urandom_range(0, 4) == 0) ? 8'($urandom)
                                : 8'($urandom_range(0, 5));
            default:        arg = 8'($urandom);
          endcase
          plan_command(op, arg, $urandom_range(0, 2));
        end
      endcase
    end
    rx = rx_plan.pop_front();

    it.signal_bit   = line_bits.pop_front();
    it.key_up       = (key_level & KEY_UP) != '0;
    it.key_preset_a = (key_level & KEY_PA) != '0;
    it.key_preset_b = (key_level & KEY_PB) != '0;
    it.key_down     = (key_level & KEY_DOWN) != '0;
    it.rx_valid     = rx[8];
    it.rx_byte      = rx[7:0];
    return it;
  endfunction

  // ---------------------------------------------------------------- drivers

  // Send one tick request and record its expected result at acceptance
  task automatic send_tick(in_item_t it);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 3);
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{IN_PAD{1'b0}}, it};
    do @(posedge clk); while (!in_tready);
    expected_results.push_back(predict_tick(it));
    ticks_sent++;
  endtask

  task automatic tick(logic sig, logic [3:0] keys, logic rx_valid, logic [7:0] rx_byte);
    in_item_t it;
    it.signal_bit   = sig;
    it.key_up       = (keys & KEY_UP) != '0;
    it.key_preset_a = (keys & KEY_PA) != '0;
    it.key_preset_b = (keys & KEY_PB) != '0;
    it.key_down     = (keys & KEY_DOWN) != '0;
    it.rx_valid     = rx_valid;
    it.rx_byte      = rx_byte;
    send_tick(it);
  endtask

  // Play out the queued line bits and serial bytes with the keys held
  task automatic play_planned(logic [3:0] keys);
    logic       sig;
    logic [8:0] rx;
    while (line_bits.size() != 0 || rx_plan.size() != 0) begin
      sig = (line_bits.size() != 0) ? line_bits.pop_front() : 1'($urandom);
      rx  = (rx_plan.size() != 0) ? rx_plan.pop_front() : {1'b0, 8'($urandom)};
      tick(sig, keys, rx[8], rx[7:0]);
    end
  endtask

  // Stop sending and wait for every expected result, then the result latency
  task automatic wait_idle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      CFG_HEIGHT_MIN:      desk_cfg.height_min       = value[7:0];
      CFG_HEIGHT_MAX:      desk_cfg.height_max       = value[7:0];
      CFG_AUTO_STOP_TICKS: desk_cfg.auto_stop_ticks  = value[15:0];
      CFG_SERIAL_GAP:      desk_cfg.serial_gap_ticks = value[15:0];
      CFG_SYNC_PATTERN:    desk_cfg.sync_pattern     = value[22:0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(logic [7:0] hmin, logic [7:0] hmax, logic [15:0] stop_ticks,
                                logic [15:0] gap_ticks, logic [22:0] pattern);
    wait_idle();
    write_reg(CFG_HEIGHT_MIN, CFG_DATA_W'(hmin));
    write_reg(CFG_HEIGHT_MAX, CFG_DATA_W'(hmax));
    write_reg(CFG_AUTO_STOP_TICKS, CFG_DATA_W'(stop_ticks));
    write_reg(CFG_SERIAL_GAP, CFG_DATA_W'(gap_ticks));
    write_reg(CFG_SYNC_PATTERN, CFG_DATA_W'(pattern));
    settings_applied++;
  endtask

  // ------------------------------------------------------------------- tests

  // Manual up/down, both keys, preset pass-through, release and all keys
  task automatic test_hand_switches();
    logic [3:0] levels[13] = '{KEY_UP, KEY_UP, KEY_NONE, KEY_DOWN, KEY_NONE,
                               KEY_UP | KEY_DOWN, KEY_NONE, KEY_PA, KEY_PB | KEY_DOWN,
                               KEY_PA | KEY_PB, KEY_NONE, KEY_UP | KEY_PA | KEY_PB | KEY_DOWN,
                               KEY_NONE};
    foreach (levels[i]) tick(1'($urandom), levels[i], 1'b0, 8'hFF);
  endtask

  // Every opcode, all preset numbers plus a bad one, a zero byte, an unknown opcode
  task automatic test_serial_commands();
    plan_command(CMD_SET_HEIGHT, 8'd80, 0);
    plan_command(CMD_STOP, 8'hFF, 0);
    plan_command(CMD_UP, 8'h5A, 1);
    plan_command(CMD_DOWN, 8'hA5, 0);
    plan_command(CMD_PRESET, PRESET_1, 0);
    plan_command(CMD_PRESET, PRESET_2, 0);
    plan_command(CMD_PRESET, PRESET_3, 0);
    plan_command(CMD_PRESET, PRESET_4, 0);
    plan_command(CMD_PRESET, 8'($urandom_range(int'(PRESET_4) + 1, 255)), 0);
    // a zero byte between the halves is skipped
    rx_plan.push_back({1'b1, CMD_SET_HEIGHT});
    rx_plan.push_back({1'b1, ZERO_BYTE});
    rx_plan.push_back({1'b1, 8'd255});
    plan_command(8'($urandom_range(int'(CMD_PRESET) + 1, 255)), 8'h33, 0);
    plan_command(CMD_STOP, 8'h01, 0);
    play_planned(KEY_NONE);
  endtask

  // While a key overrides, only serial up/down act
  task automatic test_override_moves();
    plan_command(CMD_SET_HEIGHT, 8'd90, 0);
    plan_command(CMD_DOWN, 8'h11, 0);
    plan_command(CMD_PRESET, PRESET_2, 0);
    plan_command(CMD_STOP, 8'h22, 0);
    plan_command(CMD_UP, 8'h44, 0);
    play_planned(KEY_UP);
    tick(1'($urandom), KEY_NONE, 1'b0, ZERO_BYTE);
  endtask

  // Full-range limits, a frame at the top height, then a target that wraps to zero
  task automatic test_target_wrap();
    apply_settings(8'd0, 8'd255, AUTO_STOP_TICKS_RST, SERIAL_GAP_RST, SYNC_PATTERN_RST);
    queue_height_frame(8'hFF);
    play_planned(KEY_NONE);
    plan_command(CMD_SET_HEIGHT, 8'd255, 0);
    play_planned(KEY_NONE);
    plan_command(CMD_STOP, 8'h80, 0);
    play_planned(KEY_NONE);
  endtask

  task automatic test_random_traffic(logic [7:0] hmin, logic [7:0] hmax,
                                     logic [15:0] stop_ticks, logic [15:0] gap_ticks,
                                     logic [22:0] pattern, int count);
    apply_settings(hmin, hmax, stop_ticks, gap_ticks, pattern);
    for (int i = 0; i < count; i++) begin
      // alternate stretches with and without idle cycles
      if (i % 50 == 0) steady = ($urandom_range(0, 3) == 0);
      send_tick(next_random_tick());
    end
    steady = 1'b0;
  endtask

  // ------------------------------------------------------------- result side

  // Draw a stall before each result, hold ready until one is taken
  initial begin : result_sink
    int stall;
    out_tready = 1'b0;
    wait (rst_n);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 3);
      @(negedge clk);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin : check_results
    out_item_t got;
    out_item_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[$bits(out_item_t)-1:0];
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected, got %h", $time, out_tdata);
      end else begin
        want = expected_results.pop_front();
        check_field("signal_echo", 8'(want.signal_echo), 8'(got.signal_echo));
        check_field("drive_up", 8'(want.drive_up), 8'(got.drive_up));
        check_field("drive_preset_a", 8'(want.drive_preset_a), 8'(got.drive_preset_a));
        check_field("drive_preset_b", 8'(want.drive_preset_b), 8'(got.drive_preset_b));
        check_field("drive_down", 8'(want.drive_down), 8'(got.drive_down));
        check_field("height", want.height, got.height);
        check_field("height_report", 8'(want.height_report), 8'(got.height_report));
        check_field("motion", 8'(want.motion), 8'(got.motion));
      end
    end
  end

  // Abort when neither side moves a request for too long
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("desk_height_motion_controller_top: mismatch");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------- sequence

  initial begin : run_tests
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    cfg_wr_en = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    steady    = 1'b0;
    key_level = KEY_NONE;
    key_hold  = 0;

    // predictor state after reset
    desk_cfg.height_min       = HEIGHT_MIN_RST;
    desk_cfg.height_max       = HEIGHT_MAX_RST;
    desk_cfg.auto_stop_ticks  = AUTO_STOP_TICKS_RST;
    desk_cfg.serial_gap_ticks = SERIAL_GAP_RST;
    desk_cfg.sync_pattern     = SYNC_PATTERN_RST;
    line_window  = '0;
    cur_height   = '0;
    tgt_height   = '0;
    move_dir     = MOVE_STOP;
    auto_height  = 1'b1;
    auto_preset  = 1'b0;
    key_override = 1'b0;
    drive_lv     = '0;
    idle_ticks   = '0;
    serial_quiet = '0;
    pending_op   = ZERO_BYTE;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_hand_switches();
    test_serial_commands();
    test_override_moves();
    test_target_wrap();

    test_random_traffic(HEIGHT_MIN_RST, HEIGHT_MAX_RST, AUTO_STOP_TICKS_RST, SERIAL_GAP_RST,
                        SYNC_PATTERN_RST, ITEMS_PER_PHASE);
    test_random_traffic(8'd0, 8'd255, 16'd20, 16'd6, 23'($urandom), ITEMS_PER_PHASE);
    // crossed limits: no height is ever accepted
    test_random_traffic(8'd200, 8'd100, 16'd0, 16'd0, 23'h7FFFFF, ITEMS_PER_PHASE);
    test_random_traffic(8'd90, 8'd90, 16'hFFFF, 16'hFFFF, 23'h000000, ITEMS_PER_PHASE);
    test_random_traffic(8'd40, 8'd200, 16'd40, 16'd2, 23'($urandom), ITEMS_PER_PHASE);

    wait_idle();
    $display("%0d ticks checked under %0d register settings; %0d height frames accepted",
             ticks_sent, settings_applied, heights_accepted);
    if (errors == 0) begin
      $display("desk_height_motion_controller_top: match");
    end else begin
      $display("desk_height_motion_controller_top: mismatch");
    end
    $finish;
  end

endmodule
